[hw/rtl/gpf_pkg.sv]
// Package: shared types, character codes and hex helpers for the packet framer.
package gpf_pkg;

    localparam int MaxResults = 6;
    localparam int CntW       = $clog2(MaxResults + 1);

    localparam logic [1:0] MODE_LINK  = 2'd0;
    localparam logic [1:0] MODE_SEND  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    localparam logic [1:0] KIND_LINK    = 2'd0;
    localparam logic [1:0] KIND_RX_BYTE = 2'd1;
    localparam logic [1:0] KIND_RX_END  = 2'd2;
    localparam logic [1:0] KIND_ACK     = 2'd3;

    localparam logic [7:0] CH_ESC    = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [3:0] NIBBLE    = 4'hF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RX_BODY = 3'd1,
        PH_RX_ESC  = 3'd2,
        PH_RX_HI   = 3'd3,
        PH_RX_LO   = 3'd4,
        PH_TX_BODY = 3'd5,
        PH_TX_ACK  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       status;
        logic       run_end;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]                n;
        t_result [MaxResults-1:0]       res;
    } t_batch;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] rx_sum;
        logic [3:0] rx_hi;
        logic [7:0] tx_sum;
    } t_state;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) c = 8'h30 + {4'd0, v & NIBBLE};
        else c = 8'h57 + {4'd0, v & NIBBLE};
        return c;
    endfunction

    function automatic t_result mk_result(input logic [1:0] kind, input logic [7:0] b,
                                          input logic st);
        t_result r;
        r.kind     = kind;
        r.out_byte = b;
        r.status   = st;
        r.run_end  = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/gpf_if.sv]
// Interfaces: valid/ready channels for input items and result items.
interface gpf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic       final_byte;

    modport source (output valid, mode, byte_value, final_byte, input ready);
    modport sink (input valid, mode, byte_value, final_byte, output ready);
endinterface

interface gpf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       status;
    logic       run_end;

    modport source (output valid, kind, out_byte, status, run_end, input ready);
    modport sink (input valid, kind, out_byte, status, run_end, output ready);
endinterface

[hw/rtl/gpf_core.sv]
// Framing logic: one item and the current state give the result batch and next state.
module gpf_core (
    input  gpf_pkg::t_state i_state,
    input  gpf_pkg::t_item  i_item,
    output gpf_pkg::t_batch o_batch,
    output gpf_pkg::t_state o_next
);
    import gpf_pkg::*;

    always_comb begin
        logic [CntW-1:0] n;
        logic [7:0]      ts;
        logic [7:0]      c;
        logic            bad;
        logic            idle_like;
        t_phase          ph;
        t_result [MaxResults-1:0] res;

        n   = '0;
        res = '0;
        c   = i_item.byte_value;
        ts  = i_state.tx_sum;
        ph  = i_state.phase;
        bad = 1'b0;
        o_next = i_state;
        idle_like = !(ph inside {PH_RX_BODY, PH_RX_ESC, PH_RX_HI, PH_RX_LO,
                                 PH_TX_BODY, PH_TX_ACK});

        unique case (i_item.mode)
            MODE_LINK: begin
                unique case (ph)
                    PH_RX_BODY: begin
                        if (c == CH_HASH) begin
                            ph = PH_RX_HI;
                        end else begin
                            o_next.rx_sum = i_state.rx_sum + c;
                            if (c == CH_ESC) begin
                                ph = PH_RX_ESC;
                            end else begin
                                res[n] = mk_result(KIND_RX_BYTE, c, 1'b0);
                                n = n + 1'b1;
                            end
                        end
                    end
                    PH_RX_ESC: begin
                        o_next.rx_sum = i_state.rx_sum + c;
                        res[n] = mk_result(KIND_RX_BYTE, c ^ ESC_XOR, 1'b0);
                        n = n + 1'b1;
                        ph = PH_RX_BODY;
                    end
                    PH_RX_HI: begin
                        o_next.rx_hi = hex_value(c);
                        ph = PH_RX_LO;
                    end
                    PH_RX_LO: begin
                        bad = {i_state.rx_hi, hex_value(c)} != i_state.rx_sum;
                        res[n] = mk_result(KIND_RX_END, 8'd0, bad);
                        n = n + 1'b1;
                        res[n] = mk_result(KIND_LINK, bad ? CH_MINUS : CH_PLUS, 1'b0);
                        n = n + 1'b1;
                        ph = PH_IDLE;
                    end
                    PH_TX_BODY: begin
                        ph = PH_TX_BODY;
                    end
                    PH_TX_ACK: begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            res[n] = mk_result(KIND_ACK, 8'd0, c == CH_MINUS);
                            n = n + 1'b1;
                            ph = PH_IDLE;
                        end
                    end
                    default: begin
                        if (c == CH_DOLLAR) begin
                            o_next.rx_sum = '0;
                            ph = PH_RX_BODY;
                        end else begin
                            ph = PH_IDLE;
                        end
                    end
                endcase
            end
            MODE_SEND, MODE_CLOSE: begin
                if (idle_like) begin
                    ts = '0;
                    ph = PH_TX_BODY;
                    res[n] = mk_result(KIND_LINK, CH_DOLLAR, 1'b0);
                    n = n + 1'b1;
                end
                if (ph == PH_TX_BODY) begin
                    if (i_item.mode == MODE_SEND) begin
                        if (c == CH_HASH || c == CH_DOLLAR || c == CH_ESC || c == CH_STAR) begin
                            ts = ts + CH_ESC;
                            res[n] = mk_result(KIND_LINK, CH_ESC, 1'b0);
                            n = n + 1'b1;
                            ts = ts + (c ^ ESC_XOR);
                            res[n] = mk_result(KIND_LINK, c ^ ESC_XOR, 1'b0);
                            n = n + 1'b1;
                        end else begin
                            ts = ts + c;
                            res[n] = mk_result(KIND_LINK, c, 1'b0);
                            n = n + 1'b1;
                        end
                    end
                    if (i_item.mode == MODE_CLOSE || i_item.final_byte) begin
                        res[n] = mk_result(KIND_LINK, CH_HASH, 1'b0);
                        n = n + 1'b1;
                        res[n] = mk_result(KIND_LINK, hex_char(ts[7:4]), 1'b0);
                        n = n + 1'b1;
                        res[n] = mk_result(KIND_LINK, hex_char(ts[3:0]), 1'b0);
                        n = n + 1'b1;
                        ph = PH_TX_ACK;
                    end
                end
            end
            default: begin
                ph = i_state.phase;
            end
        endcase

        if (n != '0) res[n - 1'b1].run_end = 1'b1;

        o_next.phase  = ph;
        o_next.tx_sum = ts;
        o_batch.n     = n;
        o_batch.res   = res;
    end

endmodule

[hw/rtl/gpf_seq.sv]
// Result register: holds one item's batch and hands it out one result per cycle while o_out.ready is high.
module gpf_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  gpf_pkg::t_batch   i_batch,
    output logic              o_can_load,
    gpf_out_if.source         o_out
);
    import gpf_pkg::*;

    t_result [MaxResults-1:0] r_buf;
    logic [CntW-1:0]          r_cnt;
    logic [CntW-1:0]          r_ptr;
    logic                     empty;
    logic                     take;
    logic                     last_take;
    t_result                  cur;

    assign empty      = r_ptr == r_cnt;
    assign take       = !empty && o_out.ready;
    assign last_take  = take && (r_ptr + 1'b1 == r_cnt);
    assign o_can_load = empty || last_take;
    assign cur        = r_buf[r_ptr[CntW-1:0]];

    assign o_out.valid    = !empty;
    assign o_out.kind     = cur.kind;
    assign o_out.out_byte = cur.out_byte;
    assign o_out.status   = cur.status;
    assign o_out.run_end  = cur.run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ptr <= '0;
        end else if (i_load && o_can_load) begin
            r_cnt <= i_batch.n;
            r_ptr <= '0;
        end else if (take) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) r_buf <= i_batch.res;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxResults) && r_ptr <= r_cnt)
        else $error("result pointer beyond batch");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && o_can_load && i_batch.n != '0 |=> o_out.valid && r_ptr == '0)
        else $error("loaded batch not presented");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.run_end |-> o_can_load)
        else $error("run end before batch end");

endmodule

[hw/rtl/gdb_packet_framer.sv]
// Top level: packet framer with input register, framing logic and result sequencer.
// Half-duplex framer for the remote debug serial link. Mode 0 items are link
// bytes: after '$' the payload is un-escaped and streamed out as kind 1, the two
// hex digits after '#' are checked against the 8-bit sum, and a kind 2 end mark
// (status 1 on a bad sum) is followed by a '+' or '-' link byte. Mode 1 items are
// response bytes, framed with '$', escaping and a '#' plus two-digit sum once
// final_byte is set; mode 2 closes or sends an empty frame. The acknowledgement
// then arrives as a kind 3 result. Each item yields zero to six results, the last
// one flagged by run_end. Results leave one per cycle while o_out.ready is high,
// from a single result register. The next item is taken into the input register
// while the current batch drains.
module gdb_packet_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gpf_in_if.sink     i_in,
    gpf_out_if.source  o_out
);
    import gpf_pkg::*;

    logic   r_in_valid;
    t_item  r_in;
    t_state r_state;
    t_state n_state;
    t_batch batch;
    logic   can_load;
    logic   load;

    assign load       = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.mode       <= i_in.mode;
            r_in.byte_value <= i_in.byte_value;
            r_in.final_byte <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase  <= PH_IDLE;
            r_state.rx_sum <= '0;
            r_state.rx_hi  <= '0;
            r_state.tx_sum <= '0;
        end else if (load) begin
            r_state <= n_state;
        end
    end

    gpf_core u_core (
        .i_state (r_state),
        .i_item  (r_in),
        .o_batch (batch),
        .o_next  (n_state)
    );

    gpf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !load |=> r_in_valid && $stable(r_in))
        else $error("pending item lost");

    a_state_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_state))
        else $error("state changed without an item");

    a_ack_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_state.phase == PH_TX_ACK && r_in.mode != MODE_LINK |=>
        r_state.phase == PH_TX_ACK)
        else $error("left ack wait without a link byte");

endmodule
